>>> hw/rtl/neighbor_table_aging_defines.svh
// Assertion macros for the neighbor table checker.
// Depends on nothing; included by the checker file only.
`ifndef NEIGHBOR_TABLE_AGING_DEFINES_SVH
`define NEIGHBOR_TABLE_AGING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NTA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("neighbor table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("neighbor table check failed");

`endif

>>> hw/rtl/nta_pkg.sv
// Shared types and constants of the neighbor table block.
// No dependencies; imported by every RTL module of the block.
package nta_pkg;

	localparam int ID_W       = 16;
	localparam int DIST_W     = 8;
	localparam int TIME_W     = 32;
	localparam int SLOT_W     = 3;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_MESSAGE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER    = 2'd2;

	localparam logic [DIST_W-1:0] THRESHOLD_RESET = 8'd100;
	localparam logic [TIME_W-1:0] INTERVAL_RESET  = 32'd64;
	localparam logic [ID_W-1:0]   MARKER_RESET    = 16'hFFFF;

	typedef struct packed {
		logic              command;
		logic [ID_W-1:0]   sender_id;
		logic [DIST_W-1:0] distance;
		logic [TIME_W-1:0] now;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_threshold;
		logic [TIME_W-1:0] forget_interval;
		logic [ID_W-1:0]   empty_marker;
	} cfg_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               dropped;
		logic [COUNT_W-1:0] neighbor_count;
		logic               near;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] distance;
		logic [DIST_W-1:0] prev_distance;
		logic [TIME_W-1:0] deadline;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		id: MARKER_RESET, distance: '0, prev_distance: '0, deadline: '0
	};

endpackage

>>> hw/rtl/neighbor_table_aging.sv
// Neighbor table with aging. The back end walks every slot over a single-read-port
// memory, a read state and an evaluate state per slot, and a message that finds a
// slot then revisits it to write it. The front queue can take items while a walk
// runs, but the back end starts the next item only after reporting the last one.
// Results leave on a one-cycle strobe the receiver cannot stall. Async active-low
// reset clears control, the count, the slot valid bits and restores config.
module neighbor_table_aging import nta_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic                  command,
	input  logic [ID_W-1:0]       sender_id,
	input  logic [DIST_W-1:0]     distance,
	input  logic [TIME_W-1:0]     now,
	// result strobe
	output logic                  done,
	output logic [SLOT_W-1:0]     slot,
	output logic                  dropped,
	output logic [COUNT_W-1:0]    neighbor_count,
	output logic                  near,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t        cfg_q;
	item_t       item_in;
	queue_head_t head;
	logic        pop;
	result_t     result;

	// Config writes are always taken; an index past the register list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distance_threshold <= THRESHOLD_RESET;
			cfg_q.forget_interval    <= INTERVAL_RESET;
			cfg_q.empty_marker       <= MARKER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.distance_threshold <= cfg_data[DIST_W-1:0];
				REG_INTERVAL:  cfg_q.forget_interval    <= cfg_data[TIME_W-1:0];
				REG_MARKER:    cfg_q.empty_marker       <= cfg_data[ID_W-1:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// Bundle the command fields into one item for the queue.
	assign item_in.command   = command;
	assign item_in.sender_id = sender_id;
	assign item_in.distance  = distance;
	assign item_in.now       = now;

	// Front end: take the item and queue it, so the table walk can lag behind.
	nta_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item_in (item_in),
		.head    (head),
		.pop     (pop)
	);

	// Back end: walk every slot once, then (for a message) revisit the chosen
	// slot to write it. The near flag is rebuilt from per-slot bits on each walk.
	nta_back #(.SLOTS(SLOTS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.result (result),
		.done   (done)
	);

	assign slot           = result.slot;
	assign dropped        = result.dropped;
	assign neighbor_count = result.neighbor_count;
	assign near           = result.near;

endmodule

>>> hw/rtl/nta_front.sv
// Front end: accepts command items and holds them in a two-entry queue.
// Depends on nta_pkg.
module nta_front import nta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item_in,
	output queue_head_t head,
	input  logic        pop
);

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	item_t             q_mem [QUEUE_DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;
	logic              do_pop;
	item_t             item_clean;

	// keep only the low command bit, classify as message or tick
	always_comb begin
		item_clean = item_in;
		item_clean.command = (item_in.command == CMD_TICK) ? CMD_TICK : CMD_MESSAGE;
	end

	assign busy       = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign push       = start && !busy;
	assign do_pop     = pop && (fill_q != '0);
	assign head.valid = (fill_q != '0);
	assign head.item  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= item_clean;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10:   fill_q <= fill_q + FILL_W'(1);
				2'b01:   fill_q <= fill_q - FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/nta_back.sv
// Back end: walks the neighbor table one slot at a time to update or expire.
// Depends on nta_pkg; fed by nta_front.
module nta_back import nta_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  queue_head_t head,
	output logic        pop,
	output result_t     result,
	output logic        done
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(SLOTS);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_EV, S_PICK, S_RD2, S_UPD, S_OUT
	} state_t;

	state_t           state_q;
	entry_t           mem [SLOTS];
	entry_t           rd_q;
	logic             rd_valid_q;
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] near_q;
	item_t            cur_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] match_k_q;
	logic [IDX_W-1:0] free_k_q;
	logic             match_f_q;
	logic             free_f_q;
	logic             drop_q;
	logic [CNT_W-1:0] count_q;

	entry_t ent;
	entry_t upd;
	entry_t cleared;
	entry_t wr_data;
	logic   wr_en;
	logic   is_tick;
	logic   id_hit;
	logic   id_free;
	logic   expired;
	logic   close;
	logic   new_close;

	always_comb begin
		ent      = rd_valid_q ? rd_q : ENTRY_RESET;
		is_tick  = (cur_q.command == CMD_TICK);
		id_hit   = (ent.id == cur_q.sender_id);
		id_free  = (ent.id == cfg.empty_marker);
		expired  = (ent.deadline != '0) && (cur_q.now >= ent.deadline);
		close    = (ent.id != cfg.empty_marker) && (ent.distance < cfg.distance_threshold);

		upd.id = cur_q.sender_id;
		if ((ent.distance == '0) && (ent.prev_distance == '0)) begin
			upd.distance      = cur_q.distance;
			upd.prev_distance = cur_q.distance;
		end else begin
			upd.distance      = cur_q.distance;
			upd.prev_distance = ent.distance;
		end
		upd.deadline = cur_q.now + cfg.forget_interval;
		new_close = (cur_q.sender_id != cfg.empty_marker)
			&& (cur_q.distance < cfg.distance_threshold);

		cleared = '{id: cfg.empty_marker, distance: '0, prev_distance: '0, deadline: '0};
		wr_en   = ((state_q == S_EV) && is_tick && expired) || (state_q == S_UPD);
		wr_data = (state_q == S_UPD) ? upd : cleared;
	end

	assign pop = (state_q == S_IDLE) && head.valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[k_q] <= wr_data;
		end
		rd_q <= mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			near_q     <= '0;
			cur_q      <= '0;
			k_q        <= '0;
			match_k_q  <= '0;
			free_k_q   <= '0;
			match_f_q  <= 1'b0;
			free_f_q   <= 1'b0;
			drop_q     <= 1'b0;
			count_q    <= '0;
			result     <= '0;
			done       <= 1'b0;
		end else begin
			done       <= 1'b0;
			rd_valid_q <= valid_q[k_q];
			if (wr_en) begin
				valid_q[k_q] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						cur_q     <= head.item;
						k_q       <= '0;
						match_f_q <= 1'b0;
						free_f_q  <= 1'b0;
						drop_q    <= 1'b0;
						state_q   <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (is_tick) begin
						near_q[k_q] <= !expired && close;
						if (expired && (count_q != '0)) begin
							count_q <= count_q - CNT_W'(1);
						end
					end else begin
						near_q[k_q] <= close;
						if (!match_f_q && id_hit) begin
							match_f_q <= 1'b1;
							match_k_q <= k_q;
						end
						if (!free_f_q && id_free) begin
							free_f_q <= 1'b1;
							free_k_q <= k_q;
						end
					end
					if (k_q == LAST_IDX) begin
						state_q <= is_tick ? S_OUT : S_PICK;
					end else begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_PICK: begin
					priority if (match_f_q) begin
						k_q     <= match_k_q;
						state_q <= S_RD2;
					end else if (free_f_q) begin
						k_q <= free_k_q;
						if (count_q < CNT_MAX) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_RD2;
					end else begin
						drop_q  <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_RD2: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					near_q[k_q] <= new_close;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					done                  <= 1'b1;
					result.slot           <= (is_tick || drop_q) ? '0 : SLOT_W'(k_q);
					result.dropped        <= drop_q;
					result.neighbor_count <= COUNT_W'(count_q);
					result.near           <= |near_q;
					state_q               <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/nta_checker.sv
// Port-level checks of the neighbor table, bound to the top level.
// Depends on nta_pkg and neighbor_table_aging_defines.svh.
`include "neighbor_table_aging_defines.svh"

module nta_checker import nta_pkg::*; #(
	parameter int SLOTS = 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  done,
	input logic [SLOT_W-1:0]     slot,
	input logic                  dropped,
	input logic [COUNT_W-1:0]    neighbor_count,
	input logic                  near
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	// a dropped message reports slot zero
	`NTA_ASSERT_IMPLY(a_drop_slot, clk, arst_n, done && dropped, slot == '0)
	// the count never exceeds the table size, as seen through the field width
	`NTA_ASSERT_IMPLY(a_count_max, clk, arst_n, done, neighbor_count <= COUNT_W'(CNT_W'(SLOTS)))
	// each walk ends in an idle cycle, so strobes never sit back to back
	`NTA_ASSERT_NEXT(a_strobe_gap, clk, arst_n, done, !done)

endmodule

bind neighbor_table_aging nta_checker #(.SLOTS(SLOTS)) u_nta_checker (.*);

>>> sim/tb_neighbor_table_aging.sv
// Self-checking testbench for the neighbor table with aging: a queue-fed driver, a strobe
// monitor and an in-line predictor of the table, its count and the close-neighbor flag.
// Depends on nta_pkg and neighbor_table_aging; reads no files.
module tb_neighbor_table_aging;
	import nta_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS           = 8;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 200;
	// longer than the slowest message walk through the back end
	localparam int SETTLE_CYCLES   = 2 * SLOTS + 12;
	// one past the last register; writes here must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  start          = 1'b0;
	logic                  busy;
	logic                  command        = CMD_MESSAGE;
	logic [ID_W-1:0]       sender_id      = '0;
	logic [DIST_W-1:0]     distance       = '0;
	logic [TIME_W-1:0]     now            = '0;
	logic                  done;
	logic [SLOT_W-1:0]     slot;
	logic                  dropped;
	logic [COUNT_W-1:0]    neighbor_count;
	logic                  near;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	neighbor_table_aging #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.command(command), .sender_id(sender_id), .distance(distance), .now(now),
		.done(done), .slot(slot), .dropped(dropped),
		.neighbor_count(neighbor_count), .near(near),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted copy of the table and its registers.
	logic [ID_W-1:0]   nb_id[SLOTS];
	logic [DIST_W-1:0] nb_dist[SLOTS];
	logic [DIST_W-1:0] nb_prev[SLOTS];
	logic [TIME_W-1:0] nb_deadline[SLOTS];
	int unsigned       nb_count;
	logic [DIST_W-1:0] close_threshold = THRESHOLD_RESET;
	logic [TIME_W-1:0] forget_ticks    = INTERVAL_RESET;
	logic [ID_W-1:0]   free_marker     = MARKER_RESET;

	item_t   pending_items[$];   // items not yet offered to the block
	result_t awaited_reports[$]; // predicted reports, oldest first
	item_t   offered;            // item currently on the command ports
	int      gap_left  = 0;
	int      gap_pct   = 0;      // chance in percent of an idle burst before an item
	int      errors    = 0;
	logic [TIME_W-1:0] clock_now = '0;
	logic [ID_W-1:0]   pool_base = '0;

	// Apply one item to the predicted table and return the report it should produce.
	function automatic result_t step_neighbor_table(item_t it);
		result_t rep;
		int      k;
		int      hit;
		rep = '0;
		if (it.command == CMD_TICK) begin
			for (k = 0; k < SLOTS; k++) begin
				// zero deadline never expires; plain unsigned compare, no wrap allowance
				if (nb_deadline[k] != '0 && it.now >= nb_deadline[k]) begin
					if (nb_count > 0) nb_count--;
					nb_id[k]       = free_marker;
					nb_dist[k]     = '0;
					nb_prev[k]     = '0;
					nb_deadline[k] = '0;
				end
			end
		end else begin
			hit = -1;
			// an id equal to the marker lands here on the first free slot, no count change
			for (k = 0; k < SLOTS && hit < 0; k++)
				if (nb_id[k] == it.sender_id) hit = k;
			if (hit < 0) begin
				for (k = 0; k < SLOTS && hit < 0; k++)
					if (nb_id[k] == free_marker) begin
						hit = k;
						if (nb_count < SLOTS) nb_count++;
					end
			end
			if (hit < 0) begin
				rep.dropped = 1'b1;
			end else begin
				nb_id[hit] = it.sender_id;
				// first reading fills both distances
				if (nb_dist[hit] == '0 && nb_prev[hit] == '0) begin
					nb_dist[hit] = it.distance;
					nb_prev[hit] = it.distance;
				end else begin
					nb_prev[hit] = nb_dist[hit];
					nb_dist[hit] = it.distance;
				end
				nb_deadline[hit] = it.now + forget_ticks;
				rep.slot = SLOT_W'(hit);
			end
		end
		rep.neighbor_count = COUNT_W'(nb_count);
		for (k = 0; k < SLOTS; k++)
			if (nb_id[k] != free_marker && nb_dist[k] < close_threshold) rep.near = 1'b1;
		return rep;
	endfunction

	function automatic item_t make_item(logic cmd, logic [ID_W-1:0] id,
			logic [DIST_W-1:0] dist_val, logic [TIME_W-1:0] t);
		item_t it;
		it.command   = cmd;
		it.sender_id = id;
		it.distance  = dist_val;
		it.now       = t;
		return it;
	endfunction

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver: record each accepted item, then hold it, idle for a burst, or offer the next one.
	always @(posedge clk) begin : drive_items
		logic holding;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			holding = start;
			if (start && !busy) begin
				awaited_reports.push_back(step_neighbor_table(offered));
				holding = 1'b0;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() > 0) begin
					if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
						// this cycle is the first of the burst
						gap_left = $urandom_range(1, 16) - 1;
					end else begin
						offered = pending_items.pop_front();
						holding = 1'b1;
					end
				end
			end
			start     <= holding;
			command   <= offered.command;
			sender_id <= offered.sender_id;
			distance  <= offered.distance;
			now       <= offered.now;
		end
	end

	// Monitor: every strobe must match the oldest awaited report.
	always @(posedge clk) begin : check_reports
		result_t want;
		if (arst_n && done) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected report slot=%0d dropped=%0d count=%0d near=%0d",
					$time, slot, dropped, neighbor_count, near);
				errors++;
			end else begin
				want = awaited_reports.pop_front();
				compare_field("slot", want.slot, slot);
				compare_field("dropped", want.dropped, dropped);
				compare_field("neighbor_count", want.neighbor_count, neighbor_count);
				compare_field("near", want.near, near);
			end
		end
	end

	// Write one register while the block is idle; the predictor follows at the handshake.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THRESHOLD: close_threshold = data[DIST_W-1:0];
			REG_INTERVAL:  forget_ticks    = data[TIME_W-1:0];
			REG_MARKER:    free_marker     = data[ID_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Wait until every item is taken and reported, then let the block go quiet.
	task automatic settle();
		do @(negedge clk); while (pending_items.size() != 0 || start ||
			awaited_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Queue mostly plausible traffic: ids from a small pool so the table fills, hits
	// and overflows, time that moves at a pace tied to the forget interval, and
	// a few fully random items as noise.
	task automatic fill_phase(int n);
		item_t       it;
		int unsigned span;
		int          i;
		if (forget_ticks < 16)
			span = 4;
		else if (forget_ticks > 32'h0010_0000)
			span = 32'h1000_0000;
		else
			span = forget_ticks / 4;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 5) begin
				it.command   = 1'($urandom);
				it.sender_id = ID_W'($urandom);
				it.distance  = DIST_W'($urandom);
				it.now       = $urandom;
			end else begin
				if ($urandom_range(99) < 3)
					clock_now = $urandom;
				else
					clock_now = clock_now + $urandom_range(0, span);
				it.now       = clock_now;
				it.command   = ($urandom_range(99) < 62) ? CMD_MESSAGE : CMD_TICK;
				it.sender_id = ($urandom_range(99) < 5) ? free_marker :
					ID_W'(pool_base + $urandom_range(0, 10));
				it.distance  = ($urandom_range(99) < 15) ? '0 : DIST_W'($urandom);
			end
			pending_items.push_back(it);
		end
	endtask

	initial begin : run_test
		logic [CFG_DATA_W-1:0] thr_val;
		logic [CFG_DATA_W-1:0] ivl_val;
		logic [CFG_DATA_W-1:0] mrk_val;
		int k;
		int p;
		for (k = 0; k < SLOTS; k++) begin
			nb_id[k]       = MARKER_RESET;
			nb_dist[k]     = '0;
			nb_prev[k]     = '0;
			nb_deadline[k] = '0;
		end
		nb_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings: fill, overflow, expiry, marker ids, wrap.
		@(negedge clk);
		gap_pct = 15;
		pending_items.push_back(make_item(CMD_MESSAGE, 16'h0000, 8'd0, 32'd0));
		// distances both zero after the first reading, so this one is a first reading too
		pending_items.push_back(make_item(CMD_MESSAGE, 16'h0000, 8'd50, 32'd5));
		pending_items.push_back(make_item(CMD_MESSAGE, 16'h0000, 8'd255, 32'd10));
		for (k = 1; k < SLOTS; k++)
			pending_items.push_back(make_item(CMD_MESSAGE, ID_W'(k),
				DIST_W'(k * 37), TIME_W'(10 + k)));
		// table full: a new id and a marker id are both dropped
		pending_items.push_back(make_item(CMD_MESSAGE, 16'd100, 8'd30, 32'd17));
		pending_items.push_back(make_item(CMD_MESSAGE, MARKER_RESET, 8'd30, 32'd18));
		pending_items.push_back(make_item(CMD_MESSAGE, 16'd3, 8'd0, 32'd20));
		// tick fields other than now must not matter
		pending_items.push_back(make_item(CMD_TICK, 16'hFFFF, 8'hFF, 32'd0));
		pending_items.push_back(make_item(CMD_TICK, 16'h0000, 8'h00, 32'd75));
		pending_items.push_back(make_item(CMD_TICK, 16'h0000, 8'h00, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(CMD_TICK, 16'h0000, 8'h00, 32'hFFFF_FFFF));
		// sender equal to the marker writes a slot that still reads as free
		pending_items.push_back(make_item(CMD_MESSAGE, MARKER_RESET, 8'd10, 32'd1));
		pending_items.push_back(make_item(CMD_TICK, 16'h0000, 8'h00, 32'hFFFF_FFFF));
		// deadline wraps to exactly zero: never expires
		pending_items.push_back(make_item(CMD_MESSAGE, 16'hABCD, 8'd128, 32'hFFFF_FFC0));
		pending_items.push_back(make_item(CMD_TICK, 16'h0000, 8'h00, 32'hFFFF_FFFF));
		// wrapped small deadline expires at once on a late tick
		pending_items.push_back(make_item(CMD_MESSAGE, 16'h5432, 8'd90, 32'hFFFF_FFF0));
		pending_items.push_back(make_item(CMD_TICK, 16'h0000, 8'h00, 32'hFFFF_FFF1));
		pending_items.push_back(make_item(CMD_MESSAGE, 16'hABCD, 8'd99, 32'd3));
		settle();

		// Random phases, each under its own register settings; the table carries over,
		// so marker changes with entries held are part of the run.
		for (p = 0; p < PHASES; p++) begin
			thr_val = $urandom;
			ivl_val = $urandom_range(2, 4000);
			mrk_val = $urandom;
			pool_base = ID_W'($urandom_range(0, 16'hFFF0));
			case (p)
				0: begin
					thr_val[DIST_W-1:0] = '0;
					ivl_val = 32'd1;
					mrk_val[ID_W-1:0] = '0;
					pool_base = '0;
					gap_pct = 30;
				end
				1: begin
					thr_val[DIST_W-1:0] = '1;
					ivl_val = 32'hFFFF_FFFF;
					mrk_val[ID_W-1:0] = '1;
					pool_base = 16'hFFF5;
					gap_pct = 0;
				end
				2: begin
					thr_val[DIST_W-1:0] = THRESHOLD_RESET;
					ivl_val = INTERVAL_RESET;
					gap_pct = 10;
				end
				3: gap_pct = 50;
				4: begin
					ivl_val = $urandom;
					if (ivl_val == '0) ivl_val = 32'd1;
					gap_pct = 20;
				end
				default: gap_pct = 0; // closing stretch runs without idling
			endcase
			write_register(REG_THRESHOLD, thr_val);
			write_register(REG_INTERVAL, ivl_val);
			write_register(REG_MARKER, mrk_val);
			if (p == 3) write_register(REG_UNUSED, $urandom);
			@(negedge clk);
			fill_phase(ITEMS_PER_PHASE);
			settle();
		end

		if (errors == 0 && awaited_reports.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Hang guard: far beyond the slowest legal run.
	initial begin : watchdog
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/nta_pkg.sv
hw/rtl/nta_front.sv
hw/rtl/nta_back.sv
hw/rtl/neighbor_table_aging.sv
hw/rtl/nta_checker.sv
sim/tb_neighbor_table_aging.sv
